/* src/mfhl_pkg.sv */
package mfhl_pkg;

  localparam int unsigned SIZE_W  = 28;
  localparam int unsigned COUNT_W = SIZE_W + 1;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [2:0] SYNC_TOP  = 3'b111;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_3    = 8'h33;

  localparam logic [COUNT_W-1:0] TAG_HDR_LEN  = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] SIZE_FIRST   = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] HDR_LAST     = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] MAGIC_LAST   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_I        = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_D        = COUNT_W'(1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MAGIC,
    PH_TAGHDR,
    PH_SKIP,
    PH_HUNT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]        version_code;
    logic [1:0]        layer_code;
    logic              had_tag;
    logic [SIZE_W-1:0] tag_size;
  } hdr_word_t;

  typedef struct packed {
    logic      hit;
    hdr_word_t word;
  } parse_res_t;

endpackage

/* src/mfhl_parser.sv */
module mfhl_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mfhl_pkg::byte_word_t byte_in,
  output mfhl_pkg::parse_res_t res
);
  import mfhl_pkg::*;

  phase_t             phase, phase_next, ph_e;
  logic [COUNT_W-1:0] byte_count, byte_count_next, bc_e;
  logic [SIZE_W-1:0]  size_accum, size_accum_next, sa_e;
  logic               prev_was_ff, prev_was_ff_next, pff_e;
  logic               tag_seen, tag_seen_next, ts_e;

  logic [7:0]         b;
  logic [7:0]         want;
  logic [COUNT_W-1:0] skip_end;
  logic               is_ff;
  logic               sync_hit;

  assign b = byte_in.data_byte;

  // a file start restarts the parser on this very byte
  always_comb begin
    if (byte_in.file_start) begin
      ph_e  = PH_MAGIC;
      bc_e  = '0;
      sa_e  = '0;
      pff_e = 1'b0;
      ts_e  = 1'b0;
    end else begin
      ph_e  = phase;
      bc_e  = byte_count;
      sa_e  = size_accum;
      pff_e = prev_was_ff;
      ts_e  = tag_seen;
    end
  end

  assign is_ff    = (b == SYNC_BYTE);
  assign sync_hit = pff_e && (b[7:5] == SYNC_TOP);
  assign skip_end = {1'b0, sa_e} + TAG_HDR_LEN;
  assign want     = (bc_e == POS_I) ? CHAR_I : (bc_e == POS_D) ? CHAR_D : CHAR_3;

  always_comb begin
    phase_next       = ph_e;
    byte_count_next  = bc_e;
    size_accum_next  = sa_e;
    prev_was_ff_next = pff_e;
    tag_seen_next    = ts_e;
    case (ph_e)
      PH_MAGIC: begin
        if (b == want) begin
          if (bc_e >= MAGIC_LAST) begin
            tag_seen_next = 1'b1;
            phase_next    = PH_TAGHDR;
          end
          byte_count_next = bc_e + COUNT_W'(1);
        end else begin
          // first byte of the hunt; the previous bytes were never 0xFF
          phase_next       = PH_HUNT;
          prev_was_ff_next = is_ff;
        end
      end
      PH_TAGHDR: begin
        if (bc_e >= SIZE_FIRST) begin
          size_accum_next = {sa_e[SIZE_W-8:0], b[6:0]};
        end
        if (bc_e >= HDR_LAST) begin
          phase_next = PH_SKIP;
        end
        byte_count_next = bc_e + COUNT_W'(1);
      end
      PH_SKIP: begin
        if (bc_e < skip_end) begin
          byte_count_next = bc_e + COUNT_W'(1);
        end else begin
          phase_next       = PH_HUNT;
          prev_was_ff_next = is_ff;
        end
      end
      PH_HUNT: begin
        if (sync_hit) begin
          phase_next       = PH_DONE;
          prev_was_ff_next = 1'b0;
        end else begin
          prev_was_ff_next = is_ff;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.hit               = (ph_e == PH_HUNT) && sync_hit;
    res.word.version_code = b[4:3];
    res.word.layer_code   = b[2:1];
    res.word.had_tag      = ts_e;
    res.word.tag_size     = ts_e ? sa_e : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= '0;
      size_accum  <= '0;
      prev_was_ff <= 1'b0;
      tag_seen    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      size_accum  <= size_accum_next;
      prev_was_ff <= prev_was_ff_next;
      tag_seen    <= tag_seen_next;
    end
  end

endmodule

/* src/mp3_frame_header_locator_core.sv */
// A byte accepted into the input register is parsed when the result register has
// room; a header found on it is registered into hdr_valid and hdr_data.
// Throughput: one byte per cycle, except while a held header is stalled by hdr_stall.
// Reset (rst, synchronous): empties both word registers and puts the parser
// in idle; bytes are then ignored until one arrives with file_start set.
module mp3_frame_header_locator_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  mfhl_pkg::byte_word_t byte_data,
  output logic                 hdr_valid,
  input  logic                 hdr_stall,
  output mfhl_pkg::hdr_word_t  hdr_data
);
  import mfhl_pkg::*;

  logic       in_full;
  byte_word_t in_word;
  logic       advance;
  logic       accept;
  parse_res_t res;

  // parse the held byte only when the result register has room
  assign advance    = in_full && (!hdr_valid || !hdr_stall);
  assign byte_stall = in_full && !advance;
  assign accept     = byte_valid && !byte_stall;

  mfhl_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_word),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (advance) begin
      hdr_valid <= res.hit;
    end else if (!hdr_stall) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      hdr_data <= res.word;
    end
  end

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    (in_full && !hdr_valid) |-> !byte_stall)
    else $error("input stalled while result register free");

  a_result_from_parse: assert property (@(posedge clk) disable iff (rst)
    $rose(hdr_valid) |-> $past(advance && res.hit))
    else $error("result appeared without a parsed sync");

  a_no_tag_zero_size: assert property (@(posedge clk) disable iff (rst)
    (hdr_valid && !hdr_data.had_tag) |-> (hdr_data.tag_size == '0))
    else $error("tag size reported without a tag");

endmodule

/* test/mp3_frame_header_locator_core_tb.sv */
`timescale 1ns / 1ps

module mp3_frame_header_locator_core_tb;
  import mfhl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 40;
  localparam int RANDOM_BYTES   = 800;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_word_t byte_data = '0;
  logic       hdr_valid;
  logic       hdr_stall = 1'b0;
  hdr_word_t  hdr_data;

  mp3_frame_header_locator_core u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .hdr_valid  (hdr_valid),
    .hdr_stall  (hdr_stall),
    .hdr_data   (hdr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parser shadow state
  phase_t              ph = PH_IDLE;
  logic [COUNT_W-1:0]  pos = '0;
  logic [SIZE_W-1:0]   size_acc = '0;
  logic                last_ff = 1'b0;
  logic                tag_found = 1'b0;
  hdr_word_t           hdr_expected[$];
  hdr_word_t           hdr_want;

  int          mismatches = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          idle_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic hunt_sync(input logic [7:0] b);
    hdr_word_t w;
    if (last_ff && b[7:5] == SYNC_TOP) begin
      w.version_code = b[4:3];
      w.layer_code   = b[2:1];
      w.had_tag      = tag_found;
      w.tag_size     = tag_found ? size_acc : '0;
      hdr_expected.push_back(w);
      ph      = PH_DONE;
      last_ff = 1'b0;
    end else begin
      last_ff = (b == SYNC_BYTE);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fs);
    logic [7:0] magic_char;
    if (fs) begin
      ph        = PH_MAGIC;
      pos       = '0;
      size_acc  = '0;
      last_ff   = 1'b0;
      tag_found = 1'b0;
    end
    case (ph)
      PH_MAGIC: begin
        magic_char = (pos == POS_I) ? CHAR_I : (pos == POS_D) ? CHAR_D : CHAR_3;
        if (b == magic_char) begin
          if (pos >= MAGIC_LAST) begin
            tag_found = 1'b1;
            ph        = PH_TAGHDR;
          end
          pos++;
        end else begin
          // broken magic: this byte is the first one hunted
          ph      = PH_HUNT;
          last_ff = 1'b0;
          hunt_sync(b);
        end
      end
      PH_TAGHDR: begin
        if (pos >= SIZE_FIRST)
          size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
        if (pos >= HDR_LAST)
          ph = PH_SKIP;
        pos++;
      end
      PH_SKIP: begin
        if (pos < TAG_HDR_LEN + COUNT_W'(size_acc)) begin
          pos++;
        end else begin
          ph      = PH_HUNT;
          last_ff = 1'b0;
          hunt_sync(b);
        end
      end
      PH_HUNT: hunt_sync(b);
      default: ;
    endcase
  endtask

  // Track accepted bytes
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall)
      parse_byte(byte_data.data_byte, byte_data.file_start);
  end

  // Compare each accepted header word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && hdr_valid && !hdr_stall) begin
      if (hdr_expected.size() == 0) begin
        report_mismatch("unexpected header word", 64'(hdr_data), '0);
      end else begin
        hdr_want = hdr_expected.pop_front();
        if (hdr_data.version_code !== hdr_want.version_code)
          report_mismatch("version_code", 64'(hdr_data.version_code),
                          64'(hdr_want.version_code));
        if (hdr_data.layer_code !== hdr_want.layer_code)
          report_mismatch("layer_code", 64'(hdr_data.layer_code),
                          64'(hdr_want.layer_code));
        if (hdr_data.had_tag !== hdr_want.had_tag)
          report_mismatch("had_tag", 64'(hdr_data.had_tag), 64'(hdr_want.had_tag));
        if (hdr_data.tag_size !== hdr_want.tag_size)
          report_mismatch("tag_size", 64'(hdr_data.tag_size), 64'(hdr_want.tag_size));
      end
    end
  end

  // Receiver stall pattern, switching mode now and then
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   hdr_stall <= 1'b0;
      STALL_RANDOM: hdr_stall <= ($urandom_range(0, 1) == 1);
      default:      hdr_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && !byte_stall) || (hdr_valid && !hdr_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        byte_valid <= 1'b0;
        byte_data  <= byte_word_t'(9'($urandom));
        @(negedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data  <= {b, fs};
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // 'ID3' plus seven header bytes; bit 7 of each size byte comes from junk_top
  task automatic send_tag_header(input logic [SIZE_W-1:0] size, input logic [3:0] junk_top);
    send_byte(CHAR_I, 1'b1);
    send_byte(CHAR_D, 1'b0);
    send_byte(CHAR_3, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
    for (int i = 3; i >= 0; i--)
      send_byte({junk_top[i], size[7*i +: 7]}, 1'b0);
  endtask

  task automatic send_sync(input logic [4:0] low);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte({SYNC_TOP, low}, 1'b0);
  endtask

  task automatic test_bytes_before_start();
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(CHAR_I, 1'b0);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hE2, 1'b0);
  endtask

  task automatic test_untagged_sync();
    send_byte(SYNC_BYTE, 1'b1);
    send_byte(8'hFB, 1'b0);
    // 0xFF after 0xFF completes the sync
    send_byte(8'h00, 1'b1);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(SYNC_BYTE, 1'b0);
    // near misses before the real sync
    send_byte(8'h12, 1'b1);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_sync(5'b10101);
  endtask

  task automatic test_partial_magic();
    send_byte(CHAR_I, 1'b1);
    send_byte(CHAR_D, 1'b0);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(CHAR_I, 1'b1);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hEA, 1'b0);
    send_byte(CHAR_I, 1'b1);
    send_byte(CHAR_D, 1'b0);
    send_byte(CHAR_D, 1'b0);
    send_sync(5'b01101);
  endtask

  task automatic test_tag_sizes();
    send_tag_header('0, 4'hF);
    send_sync(5'b11010);
    // 0xFF inside the skipped region must not arm the sync
    send_tag_header(28'd3, 4'h0);
    repeat (3) send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hFA, 1'b0);
    send_sync(5'b11001);
    // huge sizes: skip never ends before the next file
    send_tag_header({SIZE_W{1'b1}}, 4'h5);
    repeat (4) send_byte(SYNC_BYTE, 1'b0);
    send_tag_header(28'hAAAA555, 4'hA);
    send_sync(5'b00111);
  endtask

  task automatic test_restart_and_trailing();
    send_byte(8'h00, 1'b1);
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(8'hFB, 1'b1);
    send_sync(5'b00100);
    // ignored until the next file start
    send_sync(5'b11111);
    send_byte(CHAR_I, 1'b0);
    // restart inside the tag header
    send_byte(CHAR_I, 1'b1);
    send_byte(CHAR_D, 1'b0);
    send_byte(CHAR_3, 1'b0);
    send_byte(8'h04, 1'b0);
    send_tag_header(28'd1, 4'h3);
    send_byte(8'h55, 1'b0);
    send_sync(5'b01010);
  endtask

  task automatic send_hunt_body();
    int n;
    n = $urandom_range(0, 12);
    repeat (n)
      send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom), 1'b0);
  endtask

  task automatic test_random_files(input int n_bytes);
    int          kind;
    int          skip_len;
    logic [27:0] size;
    int          stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (kind < 5) begin
        size = 28'($urandom_range(0, 24));
        if (kind == 4)
          size = 28'($urandom);
        send_tag_header(size, 4'($urandom));
        skip_len = (size > 28'd30) ? $urandom_range(0, 30) : int'(size);
        repeat (skip_len) send_byte(8'($urandom), 1'b0);
        if (kind != 4) begin
          send_hunt_body();
          send_sync(5'($urandom));
        end
      end else if (kind < 9) begin
        send_byte(8'($urandom), 1'b1);
        send_hunt_body();
        if (kind != 8)
          send_sync(5'($urandom));
      end else begin
        repeat ($urandom_range(4, 20))
          send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      end
      repeat ($urandom_range(0, 3))
        send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bytes_before_start();
    test_untagged_sync();
    test_partial_magic();
    test_tag_sizes();
    test_restart_and_trailing();
    test_random_files(RANDOM_BYTES);

    byte_valid <= 1'b0;
    while (hdr_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
